// ===== sv/trf_pkg.sv =====
// touch report filter package: slot count, flag codes, point and lane control types
// no dependencies
package trf_pkg;

	localparam int SLOTS       = 5;
	localparam int BACKUP_SLOT = 4;
	localparam int IDX_W       = 3;
	localparam int COORD_W     = 16;

	localparam logic [7:0] FLAG_PRESSED  = 8'h80;
	localparam logic [7:0] FLAG_CAPTURED = 8'h40;
	localparam logic [7:0] KEEP_NO_PRESS = 8'h7F;
	localparam logic [7:0] KEEP_HIGH     = 8'hE0;
	localparam logic [7:0] MODE_RELEASE  = 8'h80;
	localparam logic [7:0] MODE_MASK     = 8'h8F;
	localparam logic [7:0] STATUS_READY  = 8'h80;
	localparam logic [3:0] CLEAR_LIMIT   = 4'd6;
	localparam logic [7:0] SAMPLE_PERIOD = 8'd10;
	localparam logic [7:0] TICK_LIMIT    = 8'd240;
	localparam logic [7:0] TICK_REWIND   = 8'd10;
	localparam logic [COORD_W-1:0] NO_COORD = 16'hFFFF;

	localparam int REG_SCREEN_WIDTH  = 0;
	localparam int REG_SCREEN_HEIGHT = 1;
	localparam logic [15:0] WIDTH_RESET  = 16'd800;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic load;
		logic backup;
	} lane_ctrl_t;

	// remainder of an 8-bit value by ten, via reciprocal multiply (exact for every 8-bit input)
	function automatic logic [3:0] rem10(input logic [7:0] t);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  qt;
		prod = {8'd0, t} * 16'd205;
		q    = prod[15:11];
		qt   = {3'd0, q} * SAMPLE_PERIOD;
		return 4'(t - qt);
	endfunction

endpackage

// ===== sv/trf_lane.sv =====
// one point slot lane: picks the slot's next coordinates on a request
// depends on trf_pkg
module trf_lane (
	input  trf_pkg::lane_ctrl_t ctrl,
	input  trf_pkg::point_t     point_in,
	input  trf_pkg::point_t     cur,
	input  trf_pkg::point_t     backup_src,
	output trf_pkg::point_t     next
);
	import trf_pkg::*;

	always_comb begin
		if (ctrl.load) begin
			next = point_in;
		end else if (ctrl.backup) begin
			next = backup_src;
		end else begin
			next = cur;
		end
	end

endmodule

// ===== sv/trf_merge.sv =====
// sampling, status decode and merge of the lane results into tick, flags and slot 0
// depends on trf_pkg
module trf_merge #(
	parameter int MAX_POINTS = 5
) (
	input  logic                                       accept,
	input  logic [7:0]                                 status_byte,
	input  logic [7:0]                                 caller_mode,
	input  logic [7:0]                                 tick_q,
	input  logic [7:0]                                 flags_q,
	input  logic [15:0]                                screen_width,
	input  logic [15:0]                                screen_height,
	input  trf_pkg::point_t                            stored0,
	input  trf_pkg::point_t [trf_pkg::SLOTS-1:0]       lane_res,
	output trf_pkg::lane_ctrl_t [trf_pkg::SLOTS-1:0]   lane_ctrl,
	output logic [7:0]                                 tick_next,
	output logic [7:0]                                 flags_next,
	output trf_pkg::point_t                            slot0_next,
	output logic                                       seen,
	output logic                                       clr
);
	import trf_pkg::*;

	logic [7:0] tick_inc;
	logic       sampled;
	logic [3:0] count;
	logic       taken;
	logic [SLOTS-1:0] mask;
	logic       off_screen;
	logic       restore;
	logic [7:0] mode_eff;
	logic [7:0] flags_load;
	logic [7:0] tick_tmp;
	point_t     slot0_load;

	always_comb begin
		tick_inc = tick_q + 8'd1;
		sampled  = (tick_inc < SAMPLE_PERIOD) || (rem10(tick_inc) == 4'd0);
		count    = status_byte[3:0];
		taken    = sampled && (count >= 4'd1) && (count <= 4'(MAX_POINTS));
		seen     = taken;
		clr      = sampled && ((status_byte & STATUS_READY) != 8'd0) && (count < CLEAR_LIMIT);

		for (int k = 0; k < SLOTS; k++) begin
			mask[k] = (4'(k) < count) && (k < MAX_POINTS);
			lane_ctrl[k].load   = accept && taken && mask[k];
			lane_ctrl[k].backup = accept && taken && (k == BACKUP_SLOT);
		end

		// slot 0 after the load, before the off-screen check
		off_screen = (lane_res[0].x > screen_width) || (lane_res[0].y > screen_height);
		restore    = taken && off_screen && (count == 4'd1);

		if (taken && !restore) begin
			flags_load = FLAG_PRESSED | FLAG_CAPTURED | {3'd0, mask};
		end else begin
			flags_load = flags_q;
		end

		if (taken && off_screen) begin
			slot0_load = restore ? stored0 : lane_res[1];
		end else begin
			slot0_load = lane_res[0];
		end

		if (restore) begin
			mode_eff = MODE_RELEASE;
		end else if (sampled) begin
			mode_eff = status_byte;
		end else begin
			mode_eff = caller_mode;
		end

		flags_next = flags_load;
		slot0_next = slot0_load;
		if ((mode_eff & MODE_MASK) == MODE_RELEASE) begin
			if ((flags_load & FLAG_PRESSED) != 8'd0) begin
				flags_next = flags_load & KEEP_NO_PRESS;
			end else begin
				flags_next   = flags_load & KEEP_HIGH;
				slot0_next.x = NO_COORD;
				slot0_next.y = NO_COORD;
			end
		end

		tick_tmp  = (taken && !restore) ? 8'd0 : tick_inc;
		tick_next = (tick_tmp > TICK_LIMIT) ? TICK_REWIND : tick_tmp;
	end

endmodule

// ===== sv/touch_report_filter.sv =====
// touch report filter top level: config registers, state, lanes, merge and result sequencer
// depends on trf_pkg, trf_lane, trf_merge
//
// channel   signals                         moves
// in        in_valid / in_ready             one poll tick request with status, mode, 5 points
// out       out_valid / out_ready           one slot result, five per tick, last on slot 4
// cfg       psel penable pwrite paddr ...   screen_width at 0x0, screen_height at 0x4
//
// each tick updates the state in the cycle it is taken and then gives five results,
// one a cycle while out_ready is high, read straight from the slot registers; the
// sustained tick rate is set by the single result port
// a new request is taken in the same cycle the last result of the previous one goes out
// out_ready low holds the current result; reset clears state and config to defaults
module touch_report_filter #(
	parameter int MAX_POINTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  caller_mode,
	input  logic [15:0] point0_x,
	input  logic [15:0] point0_y,
	input  logic [15:0] point1_x,
	input  logic [15:0] point1_y,
	input  logic [15:0] point2_x,
	input  logic [15:0] point2_y,
	input  logic [15:0] point3_x,
	input  logic [15:0] point3_y,
	input  logic [15:0] point4_x,
	input  logic [15:0] point4_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  point_index,
	output logic [15:0] coord_x,
	output logic [15:0] coord_y,
	output logic [7:0]  touch_flags,
	output logic        touch_seen,
	output logic        clear_status,
	output logic        last
);
	import trf_pkg::*;

	logic [15:0] width_q, height_q;
	logic [7:0]  tick_q, flags_q;
	point_t [SLOTS-1:0] stored_q;
	logic [IDX_W-1:0] idx_q;
	logic        busy_q, seen_q, clr_q;

	point_t [SLOTS-1:0]     pts;
	point_t [SLOTS-1:0]     lane_res;
	lane_ctrl_t [SLOTS-1:0] lane_ctrl;
	logic [7:0]  tick_next, flags_next;
	point_t      slot0_next;
	logic        seen_next, clr_next;
	logic        accept, out_fire, out_done, cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == 1'(REG_SCREEN_HEIGHT)) ? {16'd0, height_q} : {16'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == 1'(REG_SCREEN_HEIGHT)) begin
				height_q <= pwdata[15:0];
			end else begin
				width_q <= pwdata[15:0];
			end
		end
	end

	assign pts[0] = '{x: point0_x, y: point0_y};
	assign pts[1] = '{x: point1_x, y: point1_y};
	assign pts[2] = '{x: point2_x, y: point2_y};
	assign pts[3] = '{x: point3_x, y: point3_y};
	assign pts[4] = '{x: point4_x, y: point4_y};

	assign out_fire = out_valid && out_ready;
	assign out_done = out_fire && last;
	assign in_ready = !busy_q || out_done;
	assign accept   = in_valid && in_ready;

	for (genvar k = 0; k < SLOTS; k++) begin : g_lane
		trf_lane u_lane (
			.ctrl       (lane_ctrl[k]),
			.point_in   (pts[k]),
			.cur        (stored_q[k]),
			.backup_src (stored_q[0]),
			.next       (lane_res[k])
		);
	end

	trf_merge #(
		.MAX_POINTS (MAX_POINTS)
	) u_merge (
		.accept        (accept),
		.status_byte   (status_byte),
		.caller_mode   (caller_mode),
		.tick_q        (tick_q),
		.flags_q       (flags_q),
		.screen_width  (width_q),
		.screen_height (height_q),
		.stored0       (stored_q[0]),
		.lane_res      (lane_res),
		.lane_ctrl     (lane_ctrl),
		.tick_next     (tick_next),
		.flags_next    (flags_next),
		.slot0_next    (slot0_next),
		.seen          (seen_next),
		.clr           (clr_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			flags_q  <= '0;
			stored_q <= '0;
			seen_q   <= 1'b0;
			clr_q    <= 1'b0;
		end else if (accept) begin
			tick_q   <= tick_next;
			flags_q  <= flags_next;
			seen_q   <= seen_next;
			clr_q    <= clr_next;
			stored_q[0] <= slot0_next;
			for (int k = 1; k < SLOTS; k++) begin
				stored_q[k] <= lane_res[k];
			end
		end
	end

	// result sequencer walks the slots of the last taken tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_done) begin
			busy_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign out_valid    = busy_q;
	assign point_index  = idx_q;
	assign coord_x      = stored_q[idx_q].x;
	assign coord_y      = stored_q[idx_q].y;
	assign touch_flags  = flags_q;
	assign touch_seen   = seen_q;
	assign clear_status = clr_q;
	assign last         = (idx_q == IDX_W'(SLOTS - 1));

	a_take_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!out_valid || (out_ready && last)))
		else $error("request taken while results still pending");

	a_start_at_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (out_valid && point_index == '0))
		else $error("results of a new request do not start at slot 0");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !(in_valid && in_ready)) |=> ($stable(touch_flags) && $stable(touch_seen)))
		else $error("tick state changed while results were pending");

endmodule

// ===== tb/touch_report_filter_test.sv =====
// self-checking testbench for touch_report_filter: directed table, then shaped random poll ticks
// depends on trf_pkg and the touch_report_filter rtl; predicts all five slot results per tick
`timescale 1ns / 1ps

module touch_report_filter_test;
	import trf_pkg::*;

	localparam int MAX_PTS      = 5;
	localparam int RAND_CHUNK   = 20;
	localparam int STREAK_TICKS = 20;
	localparam int TAIL_CYCLES  = 30;
	localparam int LIMIT        = 400000;
	localparam int DIR_N        = 23;

	typedef enum logic {CHK_PREDICT, CHK_TYPED} row_check_e;

	typedef struct packed {
		logic [7:0]  status;
		logic [7:0]  mode;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic [15:0] rest;
		logic [7:0]  rep;
		row_check_e  chk;
		logic        seen;
		logic        clr;
		logic [7:0]  flg;
	} row_t;

	typedef struct {
		logic [7:0]  status;
		logic [7:0]  mode;
		logic [15:0] px [SLOTS];
		logic [15:0] py [SLOTS];
	} tick_t;

	typedef struct packed {
		logic [2:0]  idx;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  flg;
		logic        seen;
		logic        clr;
		logic        fin;
	} slot_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  status_byte = '0;
	logic [7:0]  caller_mode = '0;
	logic [15:0] point0_x = '0;
	logic [15:0] point0_y = '0;
	logic [15:0] point1_x = '0;
	logic [15:0] point1_y = '0;
	logic [15:0] point2_x = '0;
	logic [15:0] point2_y = '0;
	logic [15:0] point3_x = '0;
	logic [15:0] point3_y = '0;
	logic [15:0] point4_x = '0;
	logic [15:0] point4_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  point_index;
	logic [15:0] coord_x;
	logic [15:0] coord_y;
	logic [7:0]  touch_flags;
	logic        touch_seen;
	logic        clear_status;
	logic        last;

	// predictor state
	logic [7:0]  pred_tick;
	logic [7:0]  pred_flags;
	logic [15:0] pred_x [SLOTS];
	logic [15:0] pred_y [SLOTS];
	logic [15:0] scr_w;
	logic [15:0] scr_h;

	slot_res_t   slot_q [$];
	bit          no_gaps = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned n_ticks = 0;
	int unsigned n_loads = 0;
	int unsigned n_wraps = 0;
	int unsigned n_results = 0;
	int unsigned n_settings = 1;

	touch_report_filter #(.MAX_POINTS(MAX_PTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.status_byte(status_byte), .caller_mode(caller_mode),
		.point0_x(point0_x), .point0_y(point0_y), .point1_x(point1_x), .point1_y(point1_y),
		.point2_x(point2_x), .point2_y(point2_y), .point3_x(point3_x), .point3_y(point3_y),
		.point4_x(point4_x), .point4_y(point4_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
		.touch_flags(touch_flags), .touch_seen(touch_seen), .clear_status(clear_status),
		.last(last)
	);

	always #2ns clk = ~clk;

	// directed rows at the reset screen of 800 x 480
	row_t dir_tab [DIR_N] = '{
		// idle tick after reset
		'{8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'h00},
		'{8'h81, 8'h00, 16'd100, 16'd200, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hC1},
		// release while pressed, then release again drops point 0
		'{8'h80, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b1, 8'h41},
		'{8'h80, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b1, 8'h40},
		// five points, point 0 right on the screen edge
		'{8'h85, 8'h00, 16'd800, 16'd480, 16'h0000, 16'h0000, 16'hFFFF, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hDF},
		// five points with point 0 off-screen: backup slot already holds point 4
		'{8'h05, 8'h00, 16'd801, 16'd0, 16'd123, 16'd456, 16'h1234, 8'd1,
			CHK_TYPED, 1'b1, 1'b0, 8'hDF},
		// single point off-screen: restore and treat as release
		'{8'h81, 8'h00, 16'd0, 16'd481, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'h5F},
		'{8'h82, 8'h00, 16'hFFFF, 16'hFFFF, 16'd10, 16'd20, 16'h0000, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hC3},
		'{8'h83, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hC7},
		'{8'h84, 8'h00, 16'd799, 16'd479, 16'd1, 16'd1, 16'h7FFF, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hCF},
		// counts above the point limit, then a zero count
		'{8'h06, 8'h00, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'hCF},
		'{8'h86, 8'h00, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'hCF},
		'{8'h8F, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'hCF},
		'{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'hCF},
		'{8'h70, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'hCF},
		// upper mode bits do not hide a release
		'{8'hF0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b1, 8'h4F},
		'{8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd4,
			CHK_TYPED, 1'b0, 1'b0, 8'h4F},
		// unsampled ticks: status ignored, caller mode decides
		'{8'h81, 8'h80, 16'd5, 16'd5, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'h40},
		'{8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'h40},
		'{8'h00, 8'hF0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b0, 1'b0, 8'h40},
		'{8'h85, 8'h00, 16'd9, 16'd9, 16'd9, 16'd9, 16'd9, 8'd6,
			CHK_TYPED, 1'b0, 1'b0, 8'h40},
		// tick 20 is sampled again
		'{8'h85, 8'h00, 16'd400, 16'd240, 16'hAAAA, 16'h5555, 16'h5A5A, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'hDF},
		'{8'h81, 8'h80, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 8'd1,
			CHK_TYPED, 1'b1, 1'b1, 8'h5F}
	};

	function automatic void predictor_reset();
		pred_tick  = '0;
		pred_flags = '0;
		scr_w      = WIDTH_RESET;
		scr_h      = HEIGHT_RESET;
		for (int k = 0; k < SLOTS; k++) begin
			pred_x[k] = '0;
			pred_y[k] = '0;
		end
	endfunction

	// advance the filter state by one poll tick and queue its five slot results
	function automatic void predict_tick(input tick_t t);
		logic [7:0] mode;
		logic [7:0] saved;
		logic [3:0] cnt;
		logic       seen;
		logic       clr;
		slot_res_t  r;
		mode = t.mode;
		seen = 1'b0;
		clr  = 1'b0;
		pred_tick = pred_tick + 8'd1;
		if ((pred_tick % SAMPLE_PERIOD) == 8'd0 || pred_tick < SAMPLE_PERIOD) begin
			mode = t.status;
			cnt  = mode[3:0];
			if ((mode & STATUS_READY) != 8'd0 && cnt < CLEAR_LIMIT)
				clr = 1'b1;
			if (cnt >= 4'd1 && cnt <= 4'(MAX_PTS)) begin
				saved      = pred_flags;
				pred_flags = ((8'd1 << cnt) - 8'd1) | FLAG_PRESSED | FLAG_CAPTURED;
				pred_x[BACKUP_SLOT] = pred_x[0];
				pred_y[BACKUP_SLOT] = pred_y[0];
				for (int k = 0; k < MAX_PTS && k < SLOTS; k++) begin
					if (pred_flags[k]) begin
						pred_x[k] = t.px[k];
						pred_y[k] = t.py[k];
					end
				end
				seen = 1'b1;
				n_loads++;
				if (pred_x[0] > scr_w || pred_y[0] > scr_h) begin
					if (cnt > 4'd1) begin
						pred_x[0] = pred_x[1];
						pred_y[0] = pred_y[1];
						pred_tick = '0;
					end else begin
						pred_x[0]  = pred_x[BACKUP_SLOT];
						pred_y[0]  = pred_y[BACKUP_SLOT];
						mode       = MODE_RELEASE;
						pred_flags = saved;
					end
				end else begin
					pred_tick = '0;
				end
			end
		end
		if ((mode & MODE_MASK) == MODE_RELEASE) begin
			if ((pred_flags & FLAG_PRESSED) != 8'd0) begin
				pred_flags = pred_flags & KEEP_NO_PRESS;
			end else begin
				pred_x[0]  = NO_COORD;
				pred_y[0]  = NO_COORD;
				pred_flags = pred_flags & KEEP_HIGH;
			end
		end
		if (pred_tick > TICK_LIMIT) begin
			pred_tick = TICK_REWIND;
			n_wraps++;
		end
		for (int k = 0; k < SLOTS; k++) begin
			r.idx  = 3'(k);
			r.x    = pred_x[k];
			r.y    = pred_y[k];
			r.flg  = pred_flags;
			r.seen = seen;
			r.clr  = clr;
			r.fin  = (k == SLOTS - 1);
			slot_q.push_back(r);
		end
	endfunction

	function automatic logic [15:0] rand_coord(input logic [15:0] lim, input int on_pct);
		if ($urandom_range(99) < on_pct)
			return 16'($urandom_range(0, int'(lim)));
		return 16'($urandom);
	endfunction

	// quiet ticks carry a point count of zero or above the limit, so the counter runs into unsampled ticks
	function automatic tick_t rand_tick(input bit quiet);
		tick_t      t;
		int unsigned r;
		r = $urandom_range(99);
		if (quiet) begin
			t.status[7:4] = 4'($urandom);
			t.status[3:0] = $urandom_range(1) ? 4'd0 : 4'($urandom_range(6, 15));
		end else if (r < 60) begin
			t.status = {1'b1, 3'($urandom), 4'($urandom_range(1, MAX_PTS))};
		end else if (r < 75) begin
			t.status = {1'b1, 3'($urandom), 4'd0};
		end else begin
			t.status = 8'($urandom);
		end
		if ($urandom_range(99) < 35)
			t.mode = {1'b1, 3'($urandom), 4'd0};
		else
			t.mode = 8'($urandom);
		t.px[0] = rand_coord(scr_w, 70);
		t.py[0] = rand_coord(scr_h, 70);
		for (int k = 1; k < SLOTS; k++) begin
			t.px[k] = rand_coord(scr_w, 50);
			t.py[k] = rand_coord(scr_h, 50);
		end
		return t;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	task automatic send_tick(input tick_t t);
		if (!no_gaps && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		status_byte <= t.status;
		caller_mode <= t.mode;
		point0_x    <= t.px[0];
		point0_y    <= t.py[0];
		point1_x    <= t.px[1];
		point1_y    <= t.py[1];
		point2_x    <= t.px[2];
		point2_y    <= t.py[2];
		point3_x    <= t.px[3];
		point3_y    <= t.py[3];
		point4_x    <= t.px[4];
		point4_y    <= t.py[4];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_tick(t);
		n_ticks++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (slot_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_read_check(input int idx, input logic [15:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		flag_mismatch($sformatf("register %0d readback", idx), want, prdata[15:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input int idx, input logic [15:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx * 4);
		pwdata  <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_w = val;
		else if (idx == REG_SCREEN_HEIGHT)
			scr_h = val;
		cfg_read_check(idx, val);
	endtask

	task automatic set_screen(input logic [15:0] w, input logic [15:0] h);
		drain_results();
		cfg_write(REG_SCREEN_WIDTH, w);
		cfg_write(REG_SCREEN_HEIGHT, h);
		n_settings++;
	endtask

	// bursts of touches alternate with quiet stretches that reach unsampled ticks
	task automatic run_random(input int count, input bit mid_pause);
		int  done;
		int  len;
		bit  quiet;
		bit  paused;
		done   = 0;
		paused = 1'b0;
		while (done < count) begin
			quiet = ($urandom_range(99) < 35);
			len   = quiet ? $urandom_range(8, 20) : $urandom_range(1, 8);
			repeat (len) begin
				send_tick(rand_tick(quiet));
				done++;
			end
			if (mid_pause && !paused && done >= count / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(posedge clk)
		out_ready <= no_gaps || ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		slot_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (slot_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual slot %0d x %h y %h",
					$time, point_index, coord_x, coord_y);
				errors++;
			end else begin
				want = slot_q.pop_front();
				flag_mismatch("point_index", want.idx, point_index);
				flag_mismatch("coord_x", want.x, coord_x);
				flag_mismatch("coord_y", want.y, coord_y);
				flag_mismatch("touch_flags", want.flg, touch_flags);
				flag_mismatch("touch_seen", want.seen, touch_seen);
				flag_mismatch("clear_status", want.clr, clear_status);
				flag_mismatch("last", want.fin, last);
				n_results++;
			end
		end
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("timeout after %0d cycles, %0d results still expected", cycle_count,
			slot_q.size());
		$display("touch_report_filter_test: FAIL");
		$finish;
	end

	initial begin
		tick_t t;
		row_t  row;
		int    base;
		predictor_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		cfg_read_check(REG_SCREEN_WIDTH, WIDTH_RESET);
		cfg_read_check(REG_SCREEN_HEIGHT, HEIGHT_RESET);

		for (int i = 0; i < DIR_N; i++) begin
			row = dir_tab[i];
			t.status = row.status;
			t.mode   = row.mode;
			t.px[0]  = row.x0;
			t.py[0]  = row.y0;
			t.px[1]  = row.x1;
			t.py[1]  = row.y1;
			for (int k = 2; k < SLOTS; k++) begin
				t.px[k] = row.rest;
				t.py[k] = row.rest;
			end
			repeat (row.rep) begin
				send_tick(t);
				if (row.chk == CHK_TYPED) begin
					base = slot_q.size() - SLOTS;
					for (int k = 0; k < SLOTS; k++) begin
						slot_q[base + k].seen = row.seen;
						slot_q[base + k].clr  = row.clr;
						slot_q[base + k].flg  = row.flg;
					end
				end
			end
		end

		set_screen(16'hFFFF, 16'hFFFF);
		run_random(RAND_CHUNK, 1'b1);
		set_screen(16'h0000, 16'h0000);
		run_random(RAND_CHUNK, 1'b0);
		set_screen(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
		run_random(RAND_CHUNK, 1'b0);

		// quiet stretch with no idling on either side
		no_gaps = 1'b1;
		repeat (STREAK_TICKS)
			send_tick(rand_tick(1'b1));
		no_gaps = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d poll ticks under %0d screen settings, %0d of them loaded points",
			n_ticks, n_settings, n_loads);
		$display("checked %0d slot results, tick counter rewound %0d times",
			n_results, n_wraps);
		if (errors == 0)
			$display("touch_report_filter_test: PASS");
		else
			$display("touch_report_filter_test: FAIL");
		$finish;
	end

endmodule
